// ===== rtl/core/dual_channel_period_frequency_meter_defines.svh =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - assertion macros
// Shared concurrent assertion wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_PERIOD_FREQUENCY_METER_DEFINES_SVH
`define DUAL_CHANNEL_PERIOD_FREQUENCY_METER_DEFINES_SVH

// Check outside of reset only.
`define DCPFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check at every edge, reset included.
`define DCPFM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/dcpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - package
// Shared types and constants for the meter modules.
// ----------------------------------------------------------------------------
package dcpfm_pkg;

    localparam int DATA_W  = 32;
    localparam int FREQ_W  = 40;
    localparam int CFG_IDX_W = 8;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP = 8'd1;

    localparam logic [DATA_W-1:0] TICK_RATE_RESET   = 32'd1000000;
    localparam logic [DATA_W-1:0] COUNTER_TOP_RESET = 32'hFFFF_FFFF;

    // Job queue between front and divider
    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int JOB_PTR_W       = 1;
    localparam int JOB_CNT_W       = 2;

    typedef struct packed {
        logic              channel;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] pulse_total;
    } dcpfm_job_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } dcpfm_div_state_t;

endpackage

// ===== rtl/core/dcpfm_front.sv =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - front end
// Accepts capture events, keeps per-channel state, forms the period job.
// ----------------------------------------------------------------------------
module dcpfm_front
    import dcpfm_pkg::*;
#(
    parameter int CAPTURE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_channel,
    input  logic [DATA_W-1:0] in_capture,
    input  logic [DATA_W-1:0] counter_top,
    output logic              job_valid,
    input  logic              job_ready,
    output dcpfm_job_t        job
);

    logic [DATA_W-1:0] last_reg  [2];
    logic [DATA_W-1:0] count_reg [2];

    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] last;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] count_next;
    logic              take;

    assign now  = DATA_W'(in_capture[CAPTURE_WIDTH-1:0]);
    assign last = last_reg[in_channel];

    // Allow for one wrap of the timer at counter_top
    assign period = (now >= last) ? (now - last)
                                  : ((counter_top - last) + now + DATA_W'(1));

    assign count_next = count_reg[in_channel] + DATA_W'(1);

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign take      = in_valid & job_ready;

    assign job.channel     = in_channel;
    assign job.period      = period;
    assign job.pulse_total = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg[0]  <= '0;
            last_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end else if (take) begin
            last_reg[in_channel]  <= now;
            count_reg[in_channel] <= count_next;
        end
    end

endmodule

// ===== rtl/core/dcpfm_queue.sv =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - job queue
// Short FIFO that decouples the front end from the divider.
// ----------------------------------------------------------------------------
`include "dual_channel_period_frequency_meter_defines.svh"

module dcpfm_queue
    import dcpfm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dcpfm_job_t in_job,
    output logic       out_valid,
    input  logic       out_ready,
    output dcpfm_job_t out_job
);

    dcpfm_job_t           slot_reg [JOB_QUEUE_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != JOB_CNT_W'(JOB_QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + JOB_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + JOB_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + JOB_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

    `DCPFM_ASSERT(a_q_no_overfill, count_reg <= JOB_CNT_W'(JOB_QUEUE_DEPTH), "job queue overfilled")
    `DCPFM_ASSERT(a_q_push_fills, (push && !pop) |=> count_reg != '0, "pushed job lost")
    `DCPFM_ASSERT_ALWAYS(a_q_reset_empty, !aresetn |=> count_reg == '0, "queue not empty after reset")

endmodule

// ===== rtl/core/dcpfm_div.sv =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - back end
// Bit-serial restoring divider for tick rate over period, with result register.
// ----------------------------------------------------------------------------
`include "dual_channel_period_frequency_meter_defines.svh"

module dcpfm_div
    import dcpfm_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DATA_W-1:0] tick_rate,
    input  logic              job_valid,
    output logic              job_ready,
    input  dcpfm_job_t        job,
    output logic              out_valid,
    input  logic              out_ready,
    output dcpfm_job_t        out_job,
    output logic [FREQ_W-1:0] out_frequency
);

    localparam int DW = DATA_W + FRACTION_BITS;
    localparam int CW = $clog2(DW + 1);

    dcpfm_div_state_t  state_reg, state_next;
    logic [CW-1:0]     cnt_reg;
    logic [DW-1:0]     num_reg;
    logic [DATA_W-1:0] rem_reg;
    dcpfm_job_t        job_reg;

    logic              out_valid_reg, out_valid_next;
    dcpfm_job_t        out_job_reg;
    logic [FREQ_W-1:0] out_freq_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic [DATA_W-1:0] rem_step;
    logic [DW-1:0]     num_step;
    logic              out_free;
    logic              load_job;
    logic              do_step;
    logic              load_from_step;
    logic              load_from_hold;

    function automatic logic [FREQ_W-1:0] freq_of(input logic [DW-1:0] q,
                                                  input logic [DATA_W-1:0] p);
        logic sat;
        sat = (DW > FREQ_W) && ((q >> FREQ_W) != '0);
        if (p == '0) begin
            return '0;
        end else if (sat) begin
            return FREQ_MAX;
        end else begin
            return FREQ_W'(q);
        end
    endfunction

    // One quotient bit per cycle
    assign shifted  = {rem_reg, num_reg[DW-1]};
    assign fits     = (shifted >= {1'b0, job_reg.period});
    assign diff     = shifted - {1'b0, job_reg.period};
    assign rem_step = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    assign num_step = {num_reg[DW-2:0], fits};

    assign out_free = !out_valid_reg | out_ready;

    always_comb begin
        state_next     = state_reg;
        job_ready      = 1'b0;
        load_job       = 1'b0;
        do_step        = 1'b0;
        load_from_step = 1'b0;
        load_from_hold = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    load_job   = 1'b1;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                do_step = 1'b1;
                if (cnt_reg == CW'(1)) begin
                    if (out_free) begin
                        load_from_step = 1'b1;
                        state_next     = DIV_IDLE;
                    end else begin
                        state_next = DIV_HOLD;
                    end
                end
            end
            DIV_HOLD: begin
                if (out_free) begin
                    load_from_hold = 1'b1;
                    state_next     = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_from_step || load_from_hold) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= DIV_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_job) begin
            job_reg <= job;
            num_reg <= DW'(tick_rate) << FRACTION_BITS;
            rem_reg <= '0;
            cnt_reg <= CW'(DW);
        end else if (do_step) begin
            num_reg <= num_step;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (load_from_step) begin
            out_job_reg  <= job_reg;
            out_freq_reg <= freq_of(num_step, job_reg.period);
        end else if (load_from_hold) begin
            out_job_reg  <= job_reg;
            out_freq_reg <= freq_of(num_reg, job_reg.period);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_job       = out_job_reg;
    assign out_frequency = out_freq_reg;

    `DCPFM_ASSERT(a_div_rem_bound, (state_reg == DIV_RUN && job_reg.period != '0) |-> rem_reg < job_reg.period, "partial remainder out of range")
    `DCPFM_ASSERT(a_div_hold_busy, state_reg == DIV_HOLD |-> out_valid_reg, "holding with free result register")
    `DCPFM_ASSERT(a_div_start, load_job |=> state_reg == DIV_RUN && cnt_reg == CW'(DW), "division did not start")
    `DCPFM_ASSERT_ALWAYS(a_div_reset_out, !aresetn |=> !out_valid_reg, "result valid after reset")

endmodule

// ===== rtl/core/dual_channel_period_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - top level
// Input-capture period, pulse count and reciprocal frequency for two encoders.
// ----------------------------------------------------------------------------
// Each input transaction is one capture event: tuser selects the channel
// (0 left, 1 right) and tdata carries the latched timer value, of which the
// low CAPTURE_WIDTH bits count. For every event exactly one result
// transaction comes out carrying the period in ticks since the previous edge
// on that channel (one counter wrap at counter_top allowed), the channel's
// running pulse count, and tick_rate_hz / period as unsigned fixed point with
// FRACTION_BITS fraction bits (zero for a zero period, saturated at 40 bits).
// The front end takes an event per cycle, while the queue has room, into a
// two-entry job queue; the bit-serial restoring divider picks up one job
// when idle, forms its 32 + FRACTION_BITS quotient bits serially and waits
// while the result register is full, so it takes no new job before the last
// is done and sets the throughput. The queue, divider and result register
// hold up to four events. Write tick_rate_hz (index 0) and counter_top
// (index 1) only while no event is in flight.
// ----------------------------------------------------------------------------
module dual_channel_period_frequency_meter
    import dcpfm_pkg::*;
#(
    parameter int CAPTURE_WIDTH = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Capture events
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,     // [31:0] capture
    input  logic                 s_tuser,     // [0] channel

    // Results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [103:0]         m_tdata,     // [31:0] period,
                                              // [63:32] pulse_total,
                                              // [103:64] frequency_q8
    output logic                 m_tuser,     // [0] out_channel

    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic [DATA_W-1:0] tick_rate_reg;
    logic [DATA_W-1:0] counter_top_reg;

    dcpfm_job_t        front_job;
    logic              front_valid;
    logic              front_ready;
    dcpfm_job_t        queue_job;
    logic              queue_valid;
    logic              queue_ready;
    dcpfm_job_t        result_job;
    logic [FREQ_W-1:0] result_freq;

    // Configuration is always accepted; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg   <= TICK_RATE_RESET;
            counter_top_reg <= COUNTER_TOP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TICK_RATE:   tick_rate_reg   <= cfg_data;
                REG_COUNTER_TOP: counter_top_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: per-channel last capture and pulse count, period formation
    dcpfm_front #(
        .CAPTURE_WIDTH (CAPTURE_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_channel  (s_tuser),
        .in_capture  (s_tdata),
        .counter_top (counter_top_reg),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job         (front_job)
    );

    // Hold pending jobs so capture intake waits on the divider only when the queue is full
    dcpfm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_job   (queue_job)
    );

    // Back end: serial divide and result register
    dcpfm_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_rate     (tick_rate_reg),
        .job_valid     (queue_valid),
        .job_ready     (queue_ready),
        .job           (queue_job),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_job       (result_job),
        .out_frequency (result_freq)
    );

    // Pack the result transaction, first field lowest
    assign m_tuser = result_job.channel;
    assign m_tdata = {result_freq, result_job.pulse_total, result_job.period};

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Dual-channel period/frequency meter - testbench
// Drives capture events and register writes into the meter. Every result
// is checked field by field against typed values or an in-bench model of
// the per-channel period, pulse count and fixed-point frequency. A directed
// walk covers the corner cases, then four random phases run under different
// tick rates and counter tops; all but the last stall both sides at random.
// ----------------------------------------------------------------------------
module tb_top;
    import dcpfm_pkg::*;

    localparam int CAPTURE_WIDTH = 32;
    localparam int FRACTION_BITS = 8;
    localparam int SETTLE_CYCLES = 60;   // longer than one division
    localparam int PHASE_ITEMS   = 250;
    localparam logic [DATA_W-1:0] CAPTURE_MASK = DATA_W'((64'd1 << CAPTURE_WIDTH) - 1);

    typedef struct packed {
        logic              channel;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] pulses;
        logic [FREQ_W-1:0] freq;
    } meter_result_t;

    typedef enum logic {
        ROW_CAPTURE,
        ROW_REG_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              channel;
        logic [DATA_W-1:0] value;
        logic [CFG_IDX_W-1:0] index;
        bit                typed;
        meter_result_t     result;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [103:0]         m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // Model state: registers and per-channel capture history
    logic [DATA_W-1:0] tick_rate;
    logic [DATA_W-1:0] counter_top;
    logic [DATA_W-1:0] last_capture [2];
    logic [DATA_W-1:0] edges_seen [2];

    meter_result_t pending_results[$];
    stim_row_t     stim_rows[$];
    int unsigned   error_count = 0;
    int unsigned   captures_sent = 0;
    int unsigned   reg_writes = 0;
    int unsigned   results_checked = 0;
    bit            quiet_tail = 1'b0;   // no idling on either side when set
    int unsigned   stall_left = 0;

    dual_channel_period_frequency_meter #(
        .CAPTURE_WIDTH(CAPTURE_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Compute the result of one capture event and advance the channel state.
    // The period allows one counter wrap at counter_top; everything is
    // modulo 2^32 even when the top sits below the last capture.
    function automatic meter_result_t measure_edge(logic ch, logic [DATA_W-1:0] cap);
        meter_result_t     r;
        logic [DATA_W-1:0] now;
        logic [DATA_W-1:0] prev;
        logic [63:0]       quot;
        now  = cap & CAPTURE_MASK;
        prev = last_capture[ch];
        if (now >= prev) begin
            r.period = now - prev;
        end else begin
            r.period = (counter_top - prev) + now + 32'd1;
        end
        last_capture[ch] = now;
        edges_seen[ch]   = edges_seen[ch] + 32'd1;
        r.channel = ch;
        r.pulses  = edges_seen[ch];
        // Zero period gives zero frequency; the quotient truncates
        if (r.period == '0) begin
            quot = '0;
        end else begin
            quot = ({32'd0, tick_rate} << FRACTION_BITS) / {32'd0, r.period};
        end
        if (quot > {24'd0, FREQ_MAX}) begin
            quot = {24'd0, FREQ_MAX};
        end
        r.freq = quot[FREQ_W-1:0];
        return r;
    endfunction

    // Pick the next capture value for a channel. Most are well-formed timer
    // advances that wrap at counter_top; the rest are noise and extremes.
    function automatic logic [DATA_W-1:0] next_capture(logic ch);
        logic [63:0] span;
        logic [63:0] step;
        logic [63:0] nxt;
        int unsigned pick;
        span = {32'd0, counter_top} + 64'd1;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                return $urandom;
            end
            1: begin
                return last_capture[ch];
            end
            2: begin
                return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            end
            3: begin
                return counter_top;
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    step = {32'd0, 32'($urandom)};
                end else begin
                    step = 64'($urandom_range(1, 2000));
                end
                nxt = ({32'd0, last_capture[ch]} + step) % span;
                return nxt[DATA_W-1:0];
            end
        endcase
    endfunction

    function automatic void add_capture(logic ch, logic [DATA_W-1:0] cap);
        stim_row_t row;
        row = '{ROW_CAPTURE, ch, cap, '0, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_capture_checked(logic ch, logic [DATA_W-1:0] cap,
                                                logic [DATA_W-1:0] period,
                                                logic [DATA_W-1:0] pulses,
                                                logic [FREQ_W-1:0] freq);
        stim_row_t row;
        row = '{ROW_CAPTURE, ch, cap, '0, 1'b1, '{ch, period, pulses, freq}};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_reg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        stim_row_t row;
        row = '{ROW_REG_WRITE, 1'b0, val, idx, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    // Send one capture transaction, with an optional idle burst in front.
    // Log the expectation at the accepting edge.
    task automatic send_capture(input logic ch, input logic [DATA_W-1:0] cap,
                                input bit typed, input meter_result_t typed_result);
        int unsigned   gap;
        meter_result_t predicted;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= cap;
        do @(posedge aclk); while (!s_tready);
        predicted = measure_edge(ch, cap);
        pending_results.push_back(typed ? typed_result : predicted);
        captures_sent++;
    endtask

    // Hold the sender, drain every outstanding result, let the divider
    // settle, then write one register.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TICK_RATE:   tick_rate   = val;
            REG_COUNTER_TOP: counter_top = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Result side backpressure: random stall bursts, none in the tail
    always @(posedge aclk) begin
        if (quiet_tail) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge aclk) begin
        meter_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: channel %0d data %h", m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tuser != want.channel) begin
                    $error("out_channel: expected %0d, got %0d", want.channel, m_tuser);
                    error_count++;
                end
                if (m_tdata[31:0] != want.period) begin
                    $error("period: expected %0h, got %0h", want.period, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[63:32] != want.pulses) begin
                    $error("pulse_total: expected %0h, got %0h", want.pulses, m_tdata[63:32]);
                    error_count++;
                end
                if (m_tdata[103:64] != want.freq) begin
                    $error("frequency_q8: expected %0h, got %0h", want.freq, m_tdata[103:64]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        stim_row_t row;
        logic      ch;
        tick_rate       = TICK_RATE_RESET;
        counter_top     = COUNTER_TOP_RESET;
        last_capture[0] = '0;
        last_capture[1] = '0;
        edges_seen[0]   = '0;
        edges_seen[1]   = '0;

        // Directed walk, starting from the reset state
        // zero period on the first edge, since the reset last value is zero
        add_capture_checked(1'b0, 32'd0, 32'd0, 32'd1, 40'd0);
        // longest period: quotient truncates to zero
        add_capture_checked(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 40'd0);
        // wrap across the full 32-bit top gives a one-tick period
        add_capture_checked(1'b1, 32'd0, 32'd1, 32'd2, 40'd256000000);
        add_capture_checked(1'b0, 32'd1, 32'd1, 32'd2, 40'd256000000);
        add_capture_checked(1'b0, 32'd1001, 32'd1000, 32'd3, 40'd256000);
        // largest tick rate over one tick: top of the frequency range
        add_reg_write(REG_TICK_RATE, 32'hFFFF_FFFF);
        add_capture_checked(1'b0, 32'd1002, 32'd1, 32'd4, 40'hFF_FFFF_FF00);
        add_capture_checked(1'b1, 32'd0, 32'd0, 32'd3, 40'd0);
        // smallest top, below the last capture: wrap formula goes modulo 2^32
        add_reg_write(REG_COUNTER_TOP, 32'd1);
        add_capture(1'b0, 32'd0);
        add_capture(1'b0, 32'd1);
        add_capture(1'b0, 32'd0);
        add_capture(1'b1, 32'hFFFF_FFFF);
        // smallest tick rate
        add_reg_write(REG_TICK_RATE, 32'd1);
        add_capture(1'b1, 32'd7);
        add_capture(1'b1, 32'd1);
        // zero tick rate is out of range and reads as zero frequency
        add_reg_write(REG_TICK_RATE, 32'd0);
        add_capture_checked(1'b1, 32'd3, 32'd2, 32'd7, 40'd0);
        // ordinary top with wraps
        add_reg_write(REG_TICK_RATE, 32'd12345678);
        add_reg_write(REG_COUNTER_TOP, 32'd999);
        add_capture(1'b0, 32'd998);
        add_capture(1'b0, 32'd3);
        add_capture(1'b1, 32'd999);
        add_capture(1'b1, 32'hAAAA_5555);
        add_capture(1'b0, 32'h5555_AAAA);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_REG_WRITE) begin
                write_register(row.index, row.value);
            end else begin
                send_capture(row.channel, row.value, row.typed, row.result);
            end
        end

        // Random phases, each under its own register setting; every phase
        // change holds the sender until all results are back
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_register(REG_TICK_RATE, 32'($urandom_range(1000, 50000000)));
                    write_register(REG_COUNTER_TOP, 32'hFFFF_FFFF);
                end
                1: begin
                    write_register(REG_TICK_RATE, 32'($urandom) | 32'd1);
                    write_register(REG_COUNTER_TOP, 32'($urandom_range(1, 5000)));
                end
                2: begin
                    write_register(REG_TICK_RATE, 32'hFFFF_FFFF);
                    write_register(REG_COUNTER_TOP, 32'($urandom) | 32'd1);
                end
                default: begin
                    write_register(REG_TICK_RATE, TICK_RATE_RESET);
                    write_register(REG_COUNTER_TOP, COUNTER_TOP_RESET);
                    quiet_tail = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ch = 1'($urandom_range(0, 1));
                send_capture(ch, next_capture(ch), 1'b0, '0);
            end
        end

        // Drain, then give the block time to show any stray result
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d capture events and %0d register writes over four register settings;",
                 captures_sent, reg_writes);
        $display("checked %0d results on both channels with wraps, zero periods and extremes.",
                 results_checked);
        if (error_count == 0) begin
            $display("** dual_channel_period_frequency_meter: PASSED **");
        end else begin
            $display("** dual_channel_period_frequency_meter: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #6000000;
        $display("Timeout with %0d results still outstanding", pending_results.size());
        $display("** dual_channel_period_frequency_meter: FAILED **");
        $finish;
    end

endmodule

// ===== dual_channel_period_frequency_meter.f =====
+incdir+rtl/core
rtl/core/dcpfm_pkg.sv
rtl/core/dcpfm_front.sv
rtl/core/dcpfm_queue.sv
rtl/core/dcpfm_div.sv
rtl/core/dual_channel_period_frequency_meter.sv
tb/sv/tb_top.sv
